// ===== sv/pha_pkg.sv =====
// shared types and constants for the pulse height analyzer
// no dependencies; used by pulse_height_analyzer and its testbench
package pha_pkg;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_READ   = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        CFG_MARGIN = 2'd0,
        CFG_LOWER  = 2'd1,
        CFG_UPPER  = 2'd2
    } cfg_reg_t;

    localparam int SAMPLE_W = 12;
    localparam int BIN_W    = 7;
    localparam int UPPER_W  = 8;
    localparam int OUT_W    = 32;

    localparam logic [SAMPLE_W-1:0] RESET_MARGIN = 12'd200;
    localparam logic [BIN_W-1:0]    RESET_LOWER  = 7'd4;
    localparam logic [UPPER_W-1:0]  RESET_UPPER  = 8'd126;

    // bin = (peak >> PEAK_SHIFT) - BIN_OFFSET
    localparam int                  PEAK_SHIFT = 4;
    localparam logic [SAMPLE_W-PEAK_SHIFT-1:0] BIN_OFFSET = 8'h80;

endpackage

// ===== sv/pha_hist_mem.sv =====
// histogram store: one synchronous ram with a clearing pass after reset
// and forwarding of a write that lands on the same edge as a read
// depends on nothing outside this file
module pha_hist_mem #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    output logic [WIDTH-1:0]         rd_data,
    output logic                     clearing
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_q_reg;
    logic [WIDTH-1:0] fwd_data_reg;
    logic             fwd_hit_reg;
    logic             clearing_reg;
    logic [AW-1:0]    clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clearing_reg) begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            mem[clr_cnt_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // read sees the new word when the write hits the same entry on that edge
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data  = fwd_hit_reg ? fwd_data_reg : rd_q_reg;
    assign clearing = clearing_reg;

endmodule

// ===== sv/pulse_height_analyzer.sv =====
// pulse height analyzer top level: peak capture, histogram update, readout
// depends on pha_pkg and pha_hist_mem
//
// usage:
//   s_ channel: one request per sample pair (operation sample) or per bin
//   read (operation read). m_ channel: exactly one result per request, in
//   order. cfg_ channel: register writes, always ready, index 0 margin,
//   1 lower bin, 2 upper bin; other indexes are dropped.
//   result path: an accepted request sits in the read stage, then moves
//   into the output register once that register is empty or m_ready is
//   high; m_valid follows the output register.
//   throughput: one request per cycle while m_ready is high, sustained; the
//   histogram is a one-read one-write ram and each request does one
//   read-modify-write, with same-entry hits on back-to-back requests forwarded.
//   reset: registers return to defaults and the histogram is swept to zero,
//   one bin a cycle, with s_ready low until the sweep is done.
//   stall: with m_ready low one result waits in the output register and one
//   more request is taken into the read stage, then s_ready drops.
module pulse_height_analyzer #(
    parameter int BIN_COUNT  = 128,
    parameter int COUNT_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_operation,
    input  logic [pha_pkg::SAMPLE_W-1:0]   s_reference_sample,
    input  logic [pha_pkg::SAMPLE_W-1:0]   s_signal_sample,
    input  logic [pha_pkg::BIN_W-1:0]      s_read_bin,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_pulse_active,
    output logic                           m_peak_done,
    output logic [pha_pkg::SAMPLE_W-1:0]   m_peak_value,
    output logic [pha_pkg::BIN_W-1:0]      m_peak_bin,
    output logic                           m_counted,
    output logic [pha_pkg::OUT_W-1:0]      m_total_count,
    output logic [pha_pkg::OUT_W-1:0]      m_read_data,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [pha_pkg::SAMPLE_W-1:0]   cfg_data
);

    localparam int AW = $clog2(BIN_COUNT);
    localparam int SW = pha_pkg::SAMPLE_W;
    localparam int BW = pha_pkg::BIN_W;
    localparam int HW = pha_pkg::SAMPLE_W - pha_pkg::PEAK_SHIFT;

    // configuration registers
    logic [SW-1:0]                margin_reg;
    logic [BW-1:0]                lower_reg;
    logic [pha_pkg::UPPER_W-1:0]  upper_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_reg <= pha_pkg::RESET_MARGIN;
            lower_reg  <= pha_pkg::RESET_LOWER;
            upper_reg  <= pha_pkg::RESET_UPPER;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                pha_pkg::CFG_MARGIN: margin_reg <= cfg_data;
                pha_pkg::CFG_LOWER:  lower_reg  <= cfg_data[BW-1:0];
                pha_pkg::CFG_UPPER:  upper_reg  <= cfg_data[pha_pkg::UPPER_W-1:0];
                default: ;
            endcase
        end
    end

    // detector state
    logic [SW-1:0]         running_peak_reg, running_peak_next;
    logic                  disarmed_reg, disarmed_next;
    logic [COUNT_BITS-1:0] pulse_total_reg, pulse_total_next;

    // read stage and output register
    logic                  s1_valid_reg;
    logic                  s1_op_reg, s1_oor_reg, s1_active_reg, s1_done_reg;
    logic                  s1_counted_reg;
    logic [SW-1:0]         s1_pval_reg;
    logic [BW-1:0]         s1_pbin_reg;
    logic [AW-1:0]         s1_addr_reg;
    logic [pha_pkg::OUT_W-1:0] s1_total_reg;

    logic                  m_valid_reg;
    logic                  m_active_reg, m_done_reg, m_counted_reg;
    logic [SW-1:0]         m_pval_reg;
    logic [BW-1:0]         m_pbin_reg;
    logic [pha_pkg::OUT_W-1:0] m_total_reg, m_rdata_reg;

    logic                  mem_clearing;
    logic [COUNT_BITS-1:0] mem_rd_data;
    logic                  accept, s1_adv, is_read;
    logic                  active_c, done_c, counted_c, oor_c;
    logic [SW:0]           thresh_c;
    logic [HW-1:0]         hi_c;
    logic [BW-1:0]         bin_c;
    logic [AW-1:0]         rd_addr_c;
    logic                  wr_en_c;
    logic [COUNT_BITS-1:0] wr_data_c;
    logic [63:0]           total_wide, rdata_wide;

    assign s1_adv  = !m_valid_reg || m_ready;
    assign s_ready = !mem_clearing && (!s1_valid_reg || s1_adv);
    assign accept  = s_valid && s_ready;
    assign is_read = (s_operation == pha_pkg::OP_READ);

    // peak detection on the incoming sample pair
    always_comb begin
        thresh_c          = {1'b0, s_reference_sample} + {1'b0, margin_reg};
        active_c          = !is_read && ({1'b0, s_signal_sample} > thresh_c);
        hi_c              = running_peak_reg[SW-1:pha_pkg::PEAK_SHIFT];
        bin_c             = BW'(hi_c - pha_pkg::BIN_OFFSET);
        done_c            = 1'b0;
        counted_c         = 1'b0;
        running_peak_next = running_peak_reg;
        disarmed_next     = disarmed_reg;
        pulse_total_next  = pulse_total_reg;
        if (!is_read) begin
            if (active_c) begin
                if (!disarmed_reg) begin
                    if (s_signal_sample >= running_peak_reg) begin
                        running_peak_next = s_signal_sample;
                    end else begin
                        done_c = 1'b1;
                        // peaks below the offset give a negative bin
                        counted_c = (hi_c >= pha_pkg::BIN_OFFSET)
                            && (bin_c > lower_reg)
                            && ({1'b0, bin_c} < upper_reg)
                            && ({25'd0, bin_c} < 32'(BIN_COUNT));
                        running_peak_next = '0;
                        disarmed_next     = 1'b1;
                    end
                end
            end else begin
                disarmed_next = 1'b0;
            end
        end
        if (counted_c) begin
            pulse_total_next = pulse_total_reg + COUNT_BITS'(1);
        end
        oor_c      = ({25'd0, s_read_bin} >= 32'(BIN_COUNT));
        rd_addr_c  = is_read ? AW'(s_read_bin) : AW'(bin_c);
        total_wide = 64'(pulse_total_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_peak_reg <= '0;
            disarmed_reg     <= 1'b0;
            pulse_total_reg  <= '0;
        end else if (accept) begin
            running_peak_reg <= running_peak_next;
            disarmed_reg     <= disarmed_next;
            pulse_total_reg  <= pulse_total_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_op_reg      <= is_read;
            s1_oor_reg     <= oor_c;
            s1_active_reg  <= active_c;
            s1_done_reg    <= done_c;
            s1_counted_reg <= counted_c;
            s1_pval_reg    <= done_c ? running_peak_reg : '0;
            s1_pbin_reg    <= counted_c ? bin_c : '0;
            s1_addr_reg    <= rd_addr_c;
            s1_total_reg   <= total_wide[pha_pkg::OUT_W-1:0];
        end
    end

    // write back the incremented bin as the request leaves the read stage
    assign wr_en_c    = s1_valid_reg && s1_adv && s1_counted_reg;
    assign wr_data_c  = mem_rd_data + COUNT_BITS'(1);
    assign rdata_wide = 64'(mem_rd_data);

    pha_hist_mem #(
        .DEPTH (BIN_COUNT),
        .WIDTH (COUNT_BITS)
    ) u_hist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (accept),
        .rd_addr  (rd_addr_c),
        .wr_en    (wr_en_c),
        .wr_addr  (s1_addr_reg),
        .wr_data  (wr_data_c),
        .rd_data  (mem_rd_data),
        .clearing (mem_clearing)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_valid_reg && s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && s1_adv) begin
            m_active_reg  <= s1_active_reg;
            m_done_reg    <= s1_done_reg;
            m_counted_reg <= s1_counted_reg;
            m_pval_reg    <= s1_pval_reg;
            m_pbin_reg    <= s1_pbin_reg;
            m_total_reg   <= s1_total_reg;
            m_rdata_reg   <= (s1_op_reg && !s1_oor_reg)
                             ? rdata_wide[pha_pkg::OUT_W-1:0] : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pulse_active = m_active_reg;
    assign m_peak_done    = m_done_reg;
    assign m_peak_value   = m_pval_reg;
    assign m_peak_bin     = m_pbin_reg;
    assign m_counted      = m_counted_reg;
    assign m_total_count  = m_total_reg;
    assign m_read_data    = m_rdata_reg;

    // no request is taken while the histogram sweep is running
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_clearing |-> !accept)
        else $error("request accepted during histogram clear");

    // a captured peak disarms and restarts the running peak
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && done_c |=> disarmed_reg && (running_peak_reg == '0))
        else $error("peak capture did not disarm");

    // the pulse total moves by one exactly on a counted peak
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && counted_c |=>
            pulse_total_reg == $past(pulse_total_reg) + COUNT_BITS'(1))
        else $error("pulse total not incremented");

    // a stalled read stage never loses its request
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_addr_reg))
        else $error("read stage dropped a stalled request");

endmodule

// ===== sim/pulse_height_analyzer_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for pulse_height_analyzer: peak capture, histogram and bin reads
// depends on pha_pkg and the pulse_height_analyzer rtl; predicts every result in order
module pulse_height_analyzer_tb;

    localparam int HIST_BINS = 128;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AT = 700;
    localparam int HOLD_CYCLES = 400;
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int SW = pha_pkg::SAMPLE_W;
    localparam int BW = pha_pkg::BIN_W;
    localparam int UW = pha_pkg::UPPER_W;
    localparam int OW = pha_pkg::OUT_W;
    localparam int PS = pha_pkg::PEAK_SHIFT;

    typedef struct packed {
        pha_pkg::op_t  op;
        logic [SW-1:0] base_s;
        logic [SW-1:0] sig_s;
        logic [BW-1:0] slot;
    } pha_item_t;

    typedef struct packed {
        logic          active;
        logic          captured;
        logic [SW-1:0] peak;
        logic [BW-1:0] slot;
        logic          counted;
        logic [OW-1:0] total;
        logic [OW-1:0] rdata;
    } pha_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic          s_valid = 1'b0;
    logic          s_ready;
    logic          s_operation = 1'b0;
    logic [SW-1:0] s_reference_sample = '0;
    logic [SW-1:0] s_signal_sample = '0;
    logic [BW-1:0] s_read_bin = '0;

    logic          m_valid;
    logic          m_ready = 1'b0;
    logic          m_pulse_active;
    logic          m_peak_done;
    logic [SW-1:0] m_peak_value;
    logic [BW-1:0] m_peak_bin;
    logic          m_counted;
    logic [OW-1:0] m_total_count;
    logic [OW-1:0] m_read_data;

    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [1:0]    cfg_index = '0;
    logic [SW-1:0] cfg_data = '0;

    // predictor state, mirrors the block
    logic [SW-1:0] thr_margin = pha_pkg::RESET_MARGIN;
    logic [BW-1:0] win_lower = pha_pkg::RESET_LOWER;
    logic [UW-1:0] win_upper = pha_pkg::RESET_UPPER;
    logic [SW-1:0] track_peak = '0;
    logic          peak_locked = 1'b0;
    logic [OW-1:0] bin_counts [HIST_BINS];
    logic [OW-1:0] counted_total = '0;

    pha_item_t   pending_requests [$];
    pha_result_t predicted_results [$];
    pha_item_t   offered;

    int unsigned stim_count = 0;
    int          in_flight = 0;
    int          errors = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;

    pulse_height_analyzer #(
        .BIN_COUNT (HIST_BINS),
        .COUNT_BITS(32)
    ) i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_reference_sample(s_reference_sample),
        .s_signal_sample   (s_signal_sample),
        .s_read_bin        (s_read_bin),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pulse_active    (m_pulse_active),
        .m_peak_done       (m_peak_done),
        .m_peak_value      (m_peak_value),
        .m_peak_bin        (m_peak_bin),
        .m_counted         (m_counted),
        .m_total_count     (m_total_count),
        .m_read_data       (m_read_data),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        for (int i = 0; i < HIST_BINS; i++) begin
            bin_counts[i] = '0;
        end
    end

    task automatic predict_result(input pha_item_t it, output pha_result_t r);
        logic [SW:0]      level;
        logic [SW-PS-1:0] coarse;
        logic [SW-PS-1:0] slot;
        logic [BW-1:0]    idx;
        r = '0;
        if (it.op == pha_pkg::OP_READ) begin
            r.rdata = bin_counts[it.slot];
        end else begin
            // full-width sum, no wrap past 4095
            level = {1'b0, it.base_s} + {1'b0, thr_margin};
            if ({1'b0, it.sig_s} > level) begin
                r.active = 1'b1;
                if (!peak_locked) begin
                    if (it.sig_s >= track_peak) begin
                        track_peak = it.sig_s;
                    end else begin
                        r.captured = 1'b1;
                        r.peak = track_peak;
                        coarse = track_peak[SW-1:PS];
                        if (coarse >= pha_pkg::BIN_OFFSET) begin
                            slot = coarse - pha_pkg::BIN_OFFSET;
                            if (slot > win_lower && slot < win_upper) begin
                                idx = slot[BW-1:0];
                                bin_counts[idx] = bin_counts[idx] + 1;
                                counted_total = counted_total + 1;
                                r.counted = 1'b1;
                                r.slot = idx;
                            end
                        end
                        track_peak = '0;
                        peak_locked = 1'b1;
                    end
                end
            end else begin
                peak_locked = 1'b0;
            end
        end
        r.total = counted_total;
    endtask

    task automatic queue_item(input pha_pkg::op_t op, input int unsigned base,
                              input int unsigned sig, input int unsigned slot);
        pha_item_t it;
        it.op = op;
        it.base_s = base[SW-1:0];
        it.sig_s = sig[SW-1:0];
        it.slot = slot[BW-1:0];
        pending_requests.push_back(it);
        stim_count++;
    endtask

    task automatic queue_sample(input int unsigned base, input int unsigned sig);
        queue_item(pha_pkg::OP_SAMPLE, base, sig, $urandom_range(0, HIST_BINS - 1));
    endtask

    task automatic queue_read(input int unsigned slot);
        queue_item(pha_pkg::OP_READ, $urandom_range(0, 4095), $urandom_range(0, 4095), slot);
    endtask

    // rise, peak, optional fall, then drop below threshold to rearm
    task automatic queue_pulse(input logic with_fall);
        int unsigned peak, base, thr, lvl, steps;
        peak = ($urandom_range(0, 9) < 8) ? $urandom_range(2048, 4095)
                                          : $urandom_range(0, 4095);
        if (peak < thr_margin + 2) begin
            queue_sample($urandom_range(0, 4095), $urandom_range(0, 4095));
        end else begin
            base = $urandom_range(0, peak - thr_margin - 2);
            thr = base + thr_margin;
            if ($urandom_range(0, 1)) begin
                queue_sample(base, $urandom_range(0, thr));
            end
            lvl = thr + 1;
            steps = $urandom_range(0, 3);
            for (int i = 0; i < steps; i++) begin
                lvl = $urandom_range(lvl, peak);
                queue_sample(base, lvl);
            end
            queue_sample(base, peak);
            if (with_fall) begin
                steps = $urandom_range(1, 3);
                for (int i = 0; i < steps; i++) begin
                    queue_sample(base, $urandom_range(thr + 1, peak - 1));
                end
            end
            steps = $urandom_range(1, 2);
            for (int i = 0; i < steps; i++) begin
                queue_sample(base, $urandom_range(0, thr));
            end
        end
    endtask

    task automatic run_random(input int unsigned n);
        int unsigned goal, pick;
        goal = stim_count + n;
        while (stim_count < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                queue_pulse(1'b1);
            end else if (pick < 72) begin
                queue_pulse(1'b0);
            end else if (pick < 86) begin
                queue_read($urandom_range(0, HIST_BINS - 1));
            end else begin
                queue_sample($urandom_range(0, 4095), $urandom_range(0, 4095));
            end
        end
    endtask

    // leaves cfg_valid high so that back-to-back writes need no lowering
    task automatic write_reg(input logic [1:0] idx, input logic [SW-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        case (idx)
            pha_pkg::CFG_MARGIN: thr_margin = val;
            pha_pkg::CFG_LOWER:  win_lower = val[BW-1:0];
            pha_pkg::CFG_UPPER:  win_upper = val[UW-1:0];
            default: ;
        endcase
    endtask

    task automatic set_window(input logic [SW-1:0] margin, input logic [BW-1:0] lower,
                              input logic [UW-1:0] upper);
        write_reg(pha_pkg::CFG_MARGIN, margin);
        write_reg(pha_pkg::CFG_LOWER, {5'b0, lower});
        write_reg(pha_pkg::CFG_UPPER, {4'b0, upper});
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || in_flight != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [OW-1:0] want,
                               input logic [OW-1:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : request_drive
        pha_result_t outcome;
        pha_item_t   nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_result(offered, outcome);
                predicted_results.push_back(outcome);
            end
            if (!s_valid || s_ready) begin
                if (pending_requests.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = pending_requests.pop_front();
                    in_flight++;
                    offered = nxt;
                    s_operation <= nxt.op;
                    s_reference_sample <= nxt.base_s;
                    s_signal_sample <= nxt.sig_s;
                    s_read_bin <= nxt.slot;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_check
        pha_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    $display("%0t unexpected result: expected none, actual total %0h",
                             $time, m_total_count);
                    errors++;
                end else begin
                    want = predicted_results.pop_front();
                    in_flight--;
                    check_field("pulse_active", OW'(want.active), OW'(m_pulse_active));
                    check_field("peak_done", OW'(want.captured), OW'(m_peak_done));
                    check_field("peak_value", OW'(want.peak), OW'(m_peak_value));
                    check_field("peak_bin", OW'(want.slot), OW'(m_peak_bin));
                    check_field("counted", OW'(want.counted), OW'(m_counted));
                    check_field("total_count", want.total, m_total_count);
                    check_field("read_data", want.rdata, m_read_data);
                end
                results_seen++;
            end
            // one long hold-off so the pipeline fills and s_ready drops
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 26;
        recv_idle_pct = 68;

        // reset values in force, histogram freshly cleared
        queue_read(0);
        queue_read(HIST_BINS - 1);
        queue_sample(4095, 4095);
        queue_sample(0, 0);
        queue_sample(0, 200);      // equal to margin, not a pulse
        queue_sample(0, 201);
        queue_sample(0, 2500);
        queue_sample(0, 4095);
        queue_sample(0, 4000);     // top bin, above the window
        queue_sample(0, 3000);     // disarmed, ignored
        queue_sample(0, 0);
        queue_sample(100, 2100);
        queue_sample(100, 2200);
        queue_sample(100, 2150);   // counted
        queue_sample(0, 0);
        queue_sample(0, 1000);
        queue_sample(0, 1500);
        queue_sample(0, 1200);     // low peak, rejected
        queue_sample(0, 0);
        queue_sample(0, 2400);
        queue_sample(0, 0);        // pulse ends while armed, peak kept
        queue_sample(0, 2300);     // captures the kept peak
        queue_sample(3900, 4095);  // margin sum must not wrap
        queue_sample(0, 2112);
        queue_sample(0, 2050);     // bin equal to lower bound, rejected
        queue_read(9);
        queue_read(22);
        queue_read(4);
        wait_drained();

        write_reg(CFG_UNUSED, 12'hFFF);  // must be dropped
        set_window(12'd0, 7'd0, 8'd128);
        run_random(400);
        wait_drained();

        set_window(12'd4095, 7'd127, 8'd0);
        run_random(100);
        wait_drained();

        send_idle_pct = 68;
        recv_idle_pct = 26;
        set_window(SW'($urandom_range(0, 400)), BW'($urandom_range(0, 20)),
                   UW'($urandom_range(100, 128)));
        run_random(550);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_window(SW'($urandom_range(0, 1500)), BW'($urandom_range(0, 127)),
                   UW'($urandom_range(0, 128)));
        run_random(450);
        wait_drained();

        set_window(pha_pkg::RESET_MARGIN, pha_pkg::RESET_LOWER, pha_pkg::RESET_UPPER);
        run_random(350);
        wait_drained();

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/pha_pkg.sv
sv/pha_hist_mem.sv
sv/pulse_height_analyzer.sv
sim/pulse_height_analyzer_tb.sv
